// ===== hdl/hmt_pkg.sv =====
// ============================================================================
// hmt_pkg
// Shared types and constants of the heartbeat membership table.
// ============================================================================
package hmt_pkg;

  localparam int unsigned MaxMembersDef = 32;
  localparam int unsigned IdW           = 32;
  localparam int unsigned PortW         = 16;
  localparam int unsigned HbW           = 32;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned PeriodW       = 8;
  localparam int unsigned TimeoutW      = 16;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 32;

  typedef enum logic [1:0] {
    CMD_JOIN_REQ = 2'd0,
    CMD_JOIN_REP = 2'd1,
    CMD_GOSSIP   = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_REMOVED = 2'd1,
    KIND_JOINREP = 2'd2,
    KIND_PING    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELF_ID   = 8'd0,
    CFG_SELF_PORT = 8'd1,
    CFG_PERIOD    = 8'd2,
    CFG_TIMEOUT   = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PortW-1:0] port;
    logic [HbW-1:0]   hb;
    logic [TimeW-1:0] tstamp;
  } member_t;

  localparam int unsigned MemberW = $bits(member_t);

  typedef struct packed {
    logic [IdW-1:0]      self_id;
    logic [PortW-1:0]    self_port;
    logic [PeriodW-1:0]  period;
    logic [TimeoutW-1:0] timeout;
    logic                self_wr;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic [PortW-1:0] port;
    logic             flush;
  } emit_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic pend_valid;
  } oq_stat_t;

endpackage

// ===== hdl/hmt_in_if.sv =====
// ============================================================================
// hmt_in_if
// Input channel of the membership table: one command item per transfer.
// ============================================================================
interface hmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] peer_id;
  logic [15:0] peer_port;
  logic [31:0] entry_heartbeat;
  logic [31:0] entry_time;
  logic [31:0] sender_id;
  logic [15:0] sender_port;
  logic [31:0] now;

  modport source (
    output valid, cmd, peer_id, peer_port, entry_heartbeat, entry_time,
           sender_id, sender_port, now,
    input  ready
  );
  modport sink (
    input  valid, cmd, peer_id, peer_port, entry_heartbeat, entry_time,
           sender_id, sender_port, now,
    output ready
  );
endinterface

// ===== hdl/hmt_out_if.sv =====
// ============================================================================
// hmt_out_if
// Result channel of the membership table: one event per transfer.
// ============================================================================
interface hmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] dest_id;
  logic [15:0] dest_port;
  logic        last;

  modport source (output valid, kind, dest_id, dest_port, last, input ready);
  modport sink (input valid, kind, dest_id, dest_port, last, output ready);
endinterface

// ===== hdl/hmt_ram.sv =====
// ============================================================================
// hmt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module hmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/hmt_outq.sv =====
// ============================================================================
// hmt_outq
// Result stage: holds the newest event back until the next one or the end of
// the item is known, so that the final event of an item carries last.
// ============================================================================
module hmt_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hmt_pkg::emit_t   emit_i,
  output hmt_pkg::oq_stat_t stat_o,
  hmt_out_if.source        out_o
);
  import hmt_pkg::*;

  logic             pend_q;
  kind_e            pend_kind_q;
  logic [IdW-1:0]   pend_id_q;
  logic [PortW-1:0] pend_port_q;
  logic             ov_q;
  kind_e            o_kind_q;
  logic [IdW-1:0]   o_id_q;
  logic [PortW-1:0] o_port_q;
  logic             o_last_q;
  logic             out_free;

  assign out_free        = !ov_q || out_o.ready;
  assign stat_o.push_ok  = !pend_q || out_free;
  assign stat_o.flush_ok = !pend_q || out_free;
  assign stat_o.pend_valid = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (emit_i.valid && stat_o.push_ok) begin
        if (pend_q) begin
          ov_q <= 1'b1;
        end
        pend_q <= 1'b1;
      end else if (emit_i.flush && pend_q && out_free) begin
        ov_q   <= 1'b1;
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid && stat_o.push_ok) begin
      if (pend_q) begin
        o_kind_q <= pend_kind_q;
        o_id_q   <= pend_id_q;
        o_port_q <= pend_port_q;
        o_last_q <= 1'b0;
      end
      pend_kind_q <= emit_i.kind;
      pend_id_q   <= emit_i.id;
      pend_port_q <= emit_i.port;
    end else if (emit_i.flush && pend_q && out_free) begin
      o_kind_q <= pend_kind_q;
      o_id_q   <= pend_id_q;
      o_port_q <= pend_port_q;
      o_last_q <= 1'b1;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.kind      = o_kind_q;
  assign out_o.dest_id   = o_id_q;
  assign out_o.dest_port = o_port_q;
  assign out_o.last      = o_last_q;
endmodule

// ===== hdl/hmt_ctrl.sv =====
// ============================================================================
// hmt_ctrl
// Sequencer of the membership table: walks the slots one at a time, reading,
// updating and writing back the member memory, and issues result events.
// ============================================================================
module hmt_ctrl #(
  parameter int unsigned MaxMembers = hmt_pkg::MaxMembersDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hmt_pkg::cfg_t               cfg_i,
  hmt_in_if.sink                      in_i,
  output hmt_pkg::emit_t              emit_o,
  input  hmt_pkg::oq_stat_t           oq_i,
  output logic                        ram_we_o,
  output logic [$clog2(MaxMembers)-1:0] ram_addr_o,
  output hmt_pkg::member_t            ram_wdata_o,
  input  hmt_pkg::member_t            ram_rdata_i
);
  import hmt_pkg::*;

  localparam int unsigned SlotW = $clog2(MaxMembers);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DISP  = 8'b00000010,
    S_FREE  = 8'b00000100,
    S_ADD   = 8'b00001000,
    S_REPLY = 8'b00010000,
    S_RD    = 8'b00100000,
    S_CHK   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [IdW-1:0]      pid_q, pid_d, sid_q, sid_d;
  logic [PortW-1:0]    pport_q, pport_d, sport_q, sport_d;
  logic [HbW-1:0]      ehb_q, ehb_d;
  logic [TimeW-1:0]    etime_q, etime_d, now_q, now_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                rem_q, rem_d;
  logic [MaxMembers-1:0] valid_q, valid_d;
  logic [HbW-1:0]      hb0_q, hb0_d;
  logic [TimeW-1:0]    t0_q, t0_d;
  logic [PeriodW-1:0]  cnt_q, cnt_d;
  logic                in_group_q, in_group_d;

  logic                last_slot, adv, join_fin;
  logic                self_peer, sender_peer, rd_match, stale;
  logic [TimeW-1:0]    age;
  logic [HbW+TimeW-1:0] upd0, updr;

  function automatic logic [HbW+TimeW-1:0] upd(input logic [HbW-1:0] cur_hb,
                                               input logic [TimeW-1:0] cur_t,
                                               input logic sender,
                                               input logic [HbW-1:0] ehb,
                                               input logic [TimeW-1:0] etime,
                                               input logic [TimeW-1:0] now);
    logic [HbW-1:0]   b_hb;
    logic [TimeW-1:0] b_t;
    b_hb = sender ? ehb : cur_hb;
    b_t  = sender ? etime : cur_t;
    if (ehb > b_hb) begin
      b_hb = ehb;
      b_t  = now;
    end
    return {b_hb, b_t};
  endfunction

  assign last_slot   = slot_q == SlotW'(MaxMembers - 1);
  assign self_peer   = pid_q == cfg_i.self_id && pport_q == cfg_i.self_port;
  assign sender_peer = sid_q == pid_q && sport_q == pport_q;
  assign rd_match    = ram_rdata_i.id == pid_q && ram_rdata_i.port == pport_q;
  assign age         = now_q - ram_rdata_i.tstamp;
  assign stale       = !age[TimeW-1] && age > TimeW'(cfg_i.timeout);
  assign upd0        = upd(hb0_q, t0_q, sender_peer, ehb_q, etime_q, now_q);
  assign updr        = upd(ram_rdata_i.hb, ram_rdata_i.tstamp, sender_peer, ehb_q,
                           etime_q, now_q);

  assign in_i.ready  = state_q == S_IDLE;
  assign ram_addr_o  = slot_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    pid_d      = pid_q;
    pport_d    = pport_q;
    ehb_d      = ehb_q;
    etime_d    = etime_q;
    sid_d      = sid_q;
    sport_d    = sport_q;
    now_d      = now_q;
    slot_d     = slot_q;
    rem_d      = rem_q;
    valid_d    = valid_q;
    hb0_d      = hb0_q;
    t0_d       = t0_q;
    cnt_d      = cnt_q;
    in_group_d = in_group_q;
    adv        = 1'b0;
    join_fin   = 1'b0;
    emit_o     = '0;
    emit_o.id   = pid_q;
    emit_o.port = pport_q;
    ram_we_o   = 1'b0;
    ram_wdata_o = '{id: pid_q, port: pport_q, hb: ehb_q, tstamp: now_q};

    if (cfg_i.self_wr) begin
      in_group_d = cfg_i.self_id == IdW'(1) && cfg_i.self_port == '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = cmd_e'(in_i.cmd);
          pid_d   = in_i.peer_id;
          pport_d = in_i.peer_port;
          ehb_d   = in_i.entry_heartbeat;
          etime_d = in_i.entry_time;
          sid_d   = in_i.sender_id;
          sport_d = in_i.sender_port;
          now_d   = in_i.now;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        slot_d = SlotW'(1);
        case (cmd_q)
          CMD_JOIN_REQ, CMD_JOIN_REP: begin
            if (self_peer) begin
              join_fin = 1'b1;
            end else begin
              state_d = S_FREE;
            end
          end
          CMD_GOSSIP: begin
            if (self_peer) begin
              hb0_d   = upd0[HbW+TimeW-1:TimeW];
              t0_d    = upd0[TimeW-1:0];
              state_d = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end
          default: begin
            if (!in_group_q) begin
              state_d = S_DONE;
            end else begin
              if (cnt_q == '0) begin
                hb0_d = hb0_q + HbW'(1);
                t0_d  = now_q;
                cnt_d = cfg_i.period;
                rem_d = 1'b0;
              end else begin
                cnt_d = cnt_q - PeriodW'(1);
                rem_d = 1'b1;
              end
              state_d = S_RD;
            end
          end
        endcase
      end
      S_FREE: begin
        if (!valid_q[slot_q]) begin
          state_d = S_ADD;
        end else if (last_slot) begin
          join_fin = 1'b1;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      S_ADD: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_ADDED;
        if (oq_i.push_ok) begin
          ram_we_o        = 1'b1;
          valid_d[slot_q] = 1'b1;
          join_fin        = 1'b1;
        end
      end
      S_REPLY: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_JOINREP;
        if (oq_i.push_ok) begin
          state_d = S_DONE;
        end
      end
      S_RD: begin
        if (valid_q[slot_q]) begin
          state_d = S_CHK;
        end else begin
          adv = 1'b1;
        end
      end
      S_CHK: begin
        emit_o.id   = ram_rdata_i.id;
        emit_o.port = ram_rdata_i.port;
        if (cmd_q == CMD_GOSSIP) begin
          if (rd_match) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = '{id: ram_rdata_i.id, port: ram_rdata_i.port,
                            hb: updr[HbW+TimeW-1:TimeW], tstamp: updr[TimeW-1:0]};
            state_d     = S_DONE;
          end else begin
            adv = 1'b1;
          end
        end else if (!rem_q) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = KIND_PING;
          adv          = oq_i.push_ok;
        end else if (stale) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = KIND_REMOVED;
          if (oq_i.push_ok) begin
            valid_d[slot_q] = 1'b0;
            adv             = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      S_DONE: begin
        emit_o.flush = 1'b1;
        if (oq_i.flush_ok) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (join_fin) begin
      if (cmd_q == CMD_JOIN_REQ) begin
        state_d = S_REPLY;
      end else begin
        if (cmd_q == CMD_JOIN_REP) begin
          in_group_d = 1'b1;
        end
        state_d = S_DONE;
      end
    end

    if (adv) begin
      if (!last_slot) begin
        slot_d  = slot_q + SlotW'(1);
        state_d = S_RD;
      end else if (cmd_q == CMD_GOSSIP) begin
        slot_d  = SlotW'(1);
        state_d = S_FREE;
      end else if (!rem_q) begin
        rem_d   = 1'b1;
        slot_d  = SlotW'(1);
        state_d = S_RD;
      end else begin
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      hb0_q      <= '0;
      t0_q       <= '0;
      cnt_q      <= PeriodW'(2);
      in_group_q <= 1'b1;
      slot_q     <= '0;
      rem_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      hb0_q      <= hb0_d;
      t0_q       <= t0_d;
      cnt_q      <= cnt_d;
      in_group_q <= in_group_d;
      slot_q     <= slot_d;
      rem_q      <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pid_q   <= pid_d;
    pport_q <= pport_d;
    ehb_q   <= ehb_d;
    etime_q <= etime_d;
    sid_q   <= sid_d;
    sport_q <= sport_d;
    now_q   <= now_d;
  end
endmodule

// ===== hdl/heartbeat_membership_table.sv =====
// ============================================================================
// heartbeat_membership_table
// Gossip membership table with heartbeat-based failure detection.
// One item is in work at a time. A gossip entry scans slots 1 and up with one
// memory read and one check per valid slot, and an unknown entry adds a
// free-slot search. While in the group, a tick scans twice when it sends pings
// and once otherwise. A result is held until the next one or the end of its
// item is known and then leaves from an output register. Ready returns after
// the end. Reset empties the table and restores the register defaults.
// ============================================================================
module heartbeat_membership_table #(
  parameter int unsigned MaxMembers = hmt_pkg::MaxMembersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hmt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hmt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  hmt_in_if.sink                          in_i,
  hmt_out_if.source                       out_o
);
  import hmt_pkg::*;

  cfg_t               cfg_q;
  emit_t              emit;
  oq_stat_t           oq_stat;
  logic               ram_we;
  logic [$clog2(MaxMembers)-1:0] ram_addr;
  member_t            ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{self_id: IdW'(1), self_port: '0, period: PeriodW'(2),
                 timeout: TimeoutW'(20), self_wr: 1'b0};
    end else begin
      cfg_q.self_wr <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SELF_ID: begin
            cfg_q.self_id <= cfg_wdata_i[IdW-1:0];
            cfg_q.self_wr <= 1'b1;
          end
          CFG_SELF_PORT: begin
            cfg_q.self_port <= cfg_wdata_i[PortW-1:0];
            cfg_q.self_wr   <= 1'b1;
          end
          CFG_PERIOD: begin
            cfg_q.period <= cfg_wdata_i[PeriodW-1:0];
          end
          CFG_TIMEOUT: begin
            cfg_q.timeout <= cfg_wdata_i[TimeoutW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  hmt_ctrl #(.MaxMembers(MaxMembers)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .emit_o      (emit),
    .oq_i        (oq_stat),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  hmt_ram #(.Width(MemberW), .Depth(MaxMembers)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  hmt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .stat_o (oq_stat),
    .out_o  (out_o)
  );

  a_ready_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !oq_stat.pend_valid)
    else $error("input ready while an event is still held back");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second item taken while one is in work");

  a_emit_not_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit.valid && emit.flush))
    else $error("event issued together with end of item");
endmodule
